### src/ezyx_pkg.sv
// Shared types, sizes and helper functions for the ZYX Euler angle pipeline.
// No dependencies; used by every module in src.
package ezyx_pkg;

	localparam int DATA_WIDTH   = 16;
	localparam int CORDIC_STEPS = 16;

	// operand width after negation, squared-sum width, square root step count
	localparam int OW   = DATA_WIDTH + 1;
	localparam int SQ_W = 2 * DATA_WIDTH + 2;
	localparam int NSQ  = SQ_W / 2;
	localparam int WORK = 40;
	localparam int SH   = WORK - DATA_WIDTH;
	localparam int WW   = WORK + 4;
	localparam int ZW   = 34;
	localparam int SIW  = $clog2((NSQ > CORDIC_STEPS ? NSQ : CORDIC_STEPS) + 1);

	localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sd1686629713);
	localparam logic signed [ZW-1:0] PI_Q13      = ZW'(64'sd25736);
	localparam logic signed [ZW-1:0] HALF_PI_Q13 = ZW'(64'sd12868);

	typedef struct packed {
		logic signed [WW-1:0] x;
		logic signed [WW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} lane_t;

	typedef struct packed {
		logic [SQ_W-1:0]      rem;
		logic [SQ_W-1:0]      root;
		logic signed [OW-1:0] yaw_y;
		logic signed [OW-1:0] yaw_x;
		logic signed [OW-1:0] pit_y;
		logic signed [OW-1:0] roll_y;
		logic signed [OW-1:0] roll_x;
		logic                 lock;
		logic                 pos;
	} sq_t;

	typedef struct packed {
		lane_t yaw;
		lane_t pit;
		lane_t roll;
		logic  lock;
		logic  pos;
	} cd_t;

	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0:  v = ZW'(64'sd843314857);
			1:  v = ZW'(64'sd497837829);
			2:  v = ZW'(64'sd263043837);
			3:  v = ZW'(64'sd133525159);
			4:  v = ZW'(64'sd67021687);
			5:  v = ZW'(64'sd33543516);
			6:  v = ZW'(64'sd16775851);
			7:  v = ZW'(64'sd8388437);
			8:  v = ZW'(64'sd4194283);
			9:  v = ZW'(64'sd2097149);
			10: v = ZW'(64'sd1048576);
			11: v = ZW'(64'sd524288);
			12: v = ZW'(64'sd262144);
			13: v = ZW'(64'sd131072);
			14: v = ZW'(64'sd65536);
			15: v = ZW'(64'sd32768);
			16: v = ZW'(64'sd16384);
			17: v = ZW'(64'sd8192);
			18: v = ZW'(64'sd4096);
			19: v = ZW'(64'sd2048);
			20: v = ZW'(64'sd1024);
			21: v = ZW'(64'sd512);
			22: v = ZW'(64'sd256);
			23: v = ZW'(64'sd128);
			default: v = '0;
		endcase
		return v;
	endfunction

	// scale to the working format and fold the left half plane onto the right
	function automatic lane_t cordic_init(input logic signed [OW-1:0] y,
		input logic signed [OW-1:0] x);
		lane_t l;
		logic signed [WW-1:0] xs, ys;
		xs = WW'(x) <<< SH;
		ys = WW'(y) <<< SH;
		l.zero = (x == '0) && (y == '0);
		if (x < 0) begin
			if (y >= 0) begin
				l.x = ys;
				l.y = -xs;
				l.z = HALF_PI_Q30;
			end else begin
				l.x = -ys;
				l.y = xs;
				l.z = -HALF_PI_Q30;
			end
		end else begin
			l.x = xs;
			l.y = ys;
			l.z = '0;
		end
		return l;
	endfunction

	// round Q2.30 to Q3.13 to nearest (ties upward), then saturate at +-lim
	function automatic logic signed [ZW-1:0] round_clamp(input logic signed [ZW-1:0] z,
		input logic signed [ZW-1:0] lim);
		logic signed [ZW-1:0] r;
		r = (z + ZW'(64'sd65536)) >>> 17;
		if (r > lim)
			r = lim;
		else if (r < -lim)
			r = -lim;
		return r;
	endfunction

endpackage

### src/ezyx_sqrt_cell.sv
// One cell of the square root chain: settles one result bit per cell.
// Depends on ezyx_pkg.
module ezyx_sqrt_cell
	import ezyx_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic [SIW-1:0] step,
	input  logic           in_valid,
	output logic           in_ready,
	input  sq_t            in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output sq_t            out_data
);

	logic [SQ_W-1:0] one_hot;
	logic [SQ_W-1:0] trial;
	sq_t             nxt;
	logic            valid_q;
	sq_t             data_q;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		one_hot = {{(SQ_W-1){1'b0}}, 1'b1} << (SQ_W - 2 - 2 * int'(step));
		trial   = in_data.root + one_hot;
		nxt     = in_data;
		if (in_data.rem >= trial) begin
			nxt.rem  = in_data.rem - trial;
			nxt.root = (in_data.root >> 1) + one_hot;
		end else begin
			nxt.root = in_data.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

### src/ezyx_cordic_cell.sv
// One CORDIC micro-rotation cell, applied to the yaw, pitch and roll lanes.
// Depends on ezyx_pkg.
module ezyx_cordic_cell
	import ezyx_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic [SIW-1:0] step,
	input  logic           in_valid,
	output logic           in_ready,
	input  cd_t            in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output cd_t            out_data
);

	logic  valid_q;
	cd_t   data_q;
	cd_t   nxt;

	function automatic lane_t rotate(input lane_t l, input logic [SIW-1:0] i);
		lane_t r;
		logic signed [WW-1:0] xs, ys;
		logic signed [ZW-1:0] a;
		xs = l.x >>> i;
		ys = l.y >>> i;
		a  = atan_q30(int'(i));
		r  = l;
		if (!l.y[WW-1]) begin
			r.x = l.x + ys;
			r.y = l.y - xs;
			r.z = l.z + a;
		end else begin
			r.x = l.x - ys;
			r.y = l.y + xs;
			r.z = l.z - a;
		end
		return r;
	endfunction

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		nxt      = in_data;
		nxt.yaw  = rotate(in_data.yaw, step);
		nxt.pit  = rotate(in_data.pit, step);
		nxt.roll = rotate(in_data.roll, step);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

### src/euler_zyx_from_rotation_matrix.sv
// Z-Y-X Euler angles from a rotation matrix: entry stage, square root
// chain, CORDIC chain, output register. Depends on ezyx_pkg and the cells.
//
// Usage:
//   Input beat: seven Q2.14 matrix entries on in_valid/in_ready.
//   Output beat: yaw and roll in Q3.13, pitch in Q2.13, all radians, plus
//   gimbal_lock on out_valid/out_ready. Results leave in input order,
//   one per input beat. Stages: 1 entry stage, NSQ square root cells,
//   CORDIC_STEPS rotation cells and 1 output register.
//   Throughput: one matrix per cycle unless the receiver stalls; every cell
//   has its own valid bit and loads whenever its successor is empty or moving,
//   so bubbles collapse. A stalled receiver holds the output register; the
//   chain keeps taking beats until every cell is full, then in_ready drops.
//   The square root cells settle one root bit each (sqrt of m00^2+m10^2
//   feeds pitch), so they sit ahead of the rotation cells.
//   Reset clears all valid bits; no item survives it and nothing else is
//   kept between items.
module euler_zyx_from_rotation_matrix
	import ezyx_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] m00,
	input  logic signed [DATA_WIDTH-1:0] m10,
	input  logic signed [DATA_WIDTH-1:0] m20,
	input  logic signed [DATA_WIDTH-1:0] m21,
	input  logic signed [DATA_WIDTH-1:0] m22,
	input  logic signed [DATA_WIDTH-1:0] m01,
	input  logic signed [DATA_WIDTH-1:0] m11,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [15:0]           yaw,
	output logic signed [14:0]           pitch,
	output logic signed [15:0]           roll,
	output logic                         gimbal_lock
);

	sq_t  sq_d [NSQ+1];
	logic sq_v [NSQ+1];
	logic sq_r [NSQ+1];
	cd_t  cd_d [CORDIC_STEPS+1];
	logic cd_v [CORDIC_STEPS+1];
	logic cd_r [CORDIC_STEPS+1];

	sq_t             entry;
	logic [DATA_WIDTH-1:0] abs00, abs10;
	sq_t             entry_q;
	logic            entry_v_q;
	logic            lock;
	logic            pos;

	always_comb begin
		lock  = (m00 == '0) && (m10 == '0);
		pos   = m20 > 0;
		abs00 = m00[DATA_WIDTH-1] ? DATA_WIDTH'(-m00) : DATA_WIDTH'(m00);
		abs10 = m10[DATA_WIDTH-1] ? DATA_WIDTH'(-m10) : DATA_WIDTH'(m10);
		entry.rem    = SQ_W'(abs00) * SQ_W'(abs00) + SQ_W'(abs10) * SQ_W'(abs10);
		entry.root   = '0;
		entry.yaw_y  = OW'(m10);
		entry.yaw_x  = OW'(m00);
		entry.pit_y  = -OW'(m20);
		entry.lock   = lock;
		entry.pos    = pos;
		if (lock) begin
			entry.roll_y = pos ? -OW'(m01) : OW'(m01);
			entry.roll_x = OW'(m11);
		end else begin
			entry.roll_y = OW'(m21);
			entry.roll_x = OW'(m22);
		end
	end

	assign in_ready = !entry_v_q || sq_r[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_v_q <= 1'b0;
		end else if (in_ready) begin
			entry_v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			entry_q <= entry;
		end
	end

	assign sq_d[0] = entry_q;
	assign sq_v[0] = entry_v_q;

	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		ezyx_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (SIW'(k)),
			.in_valid  (sq_v[k]),
			.in_ready  (sq_r[k]),
			.in_data   (sq_d[k]),
			.out_valid (sq_v[k+1]),
			.out_ready (sq_r[k+1]),
			.out_data  (sq_d[k+1])
		);
	end

	// prepare the three rotation lanes from the finished root
	always_comb begin
		cd_d[0].yaw  = cordic_init(sq_d[NSQ].yaw_y, sq_d[NSQ].yaw_x);
		cd_d[0].pit  = cordic_init(sq_d[NSQ].pit_y, OW'(sq_d[NSQ].root));
		cd_d[0].roll = cordic_init(sq_d[NSQ].roll_y, sq_d[NSQ].roll_x);
		cd_d[0].lock = sq_d[NSQ].lock;
		cd_d[0].pos  = sq_d[NSQ].pos;
	end
	assign cd_v[0]   = sq_v[NSQ];
	assign sq_r[NSQ] = cd_r[0];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		ezyx_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (SIW'(i)),
			.in_valid  (cd_v[i]),
			.in_ready  (cd_r[i]),
			.in_data   (cd_d[i]),
			.out_valid (cd_v[i+1]),
			.out_ready (cd_r[i+1]),
			.out_data  (cd_d[i+1])
		);
	end

	cd_t                  fin;
	logic signed [ZW-1:0] yaw_a, pit_a, roll_a;
	logic                 out_v_q;
	logic signed [15:0]   yaw_q, roll_q;
	logic signed [14:0]   pitch_q;
	logic                 lock_q;

	assign fin = cd_d[CORDIC_STEPS];
	assign cd_r[CORDIC_STEPS] = !out_v_q || out_ready;

	always_comb begin
		yaw_a  = fin.yaw.zero ? '0 : round_clamp(fin.yaw.z, PI_Q13);
		roll_a = fin.roll.zero ? '0 : round_clamp(fin.roll.z, PI_Q13);
		pit_a  = fin.pit.zero ? '0 : round_clamp(fin.pit.z, HALF_PI_Q13);
		if (fin.lock) begin
			yaw_a = '0;
			pit_a = fin.pos ? -HALF_PI_Q13 : HALF_PI_Q13;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cd_r[CORDIC_STEPS]) begin
			out_v_q <= cd_v[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (cd_r[CORDIC_STEPS] && cd_v[CORDIC_STEPS]) begin
			yaw_q   <= yaw_a[15:0];
			pitch_q <= pit_a[14:0];
			roll_q  <= roll_a[15:0];
			lock_q  <= fin.lock;
		end
	end

	assign out_valid   = out_v_q;
	assign yaw         = yaw_q;
	assign pitch       = pitch_q;
	assign roll        = roll_q;
	assign gimbal_lock = lock_q;

endmodule

### src/ezyx_checker.sv
// Port-level checks for euler_zyx_from_rotation_matrix, bound to the top level.
// Depends on ezyx_pkg.
module ezyx_checker
	import ezyx_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] yaw,
	input logic signed [14:0] pitch,
	input logic signed [15:0] roll,
	input logic               gimbal_lock
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(yaw) && $stable(pitch) && $stable(roll))
		else $error("output beat changed while stalled");

	a_lock_yaw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && gimbal_lock |-> yaw == 16'sd0 &&
		(pitch == 15'sd12868 || pitch == -15'sd12868))
		else $error("gimbal lock beat with bad yaw or pitch");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> yaw <= 16'sd25736 && yaw >= -16'sd25736 &&
		roll <= 16'sd25736 && roll >= -16'sd25736 &&
		pitch <= 15'sd12868 && pitch >= -15'sd12868)
		else $error("angle out of range");

endmodule

bind euler_zyx_from_rotation_matrix ezyx_checker u_ezyx_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.yaw         (yaw),
	.pitch       (pitch),
	.roll        (roll),
	.gimbal_lock (gimbal_lock)
);
